// ----- sv/bpd_pkg.sv -----
package bpd_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int MAX_RUN     = 64;
   localparam int TABLE_DEPTH = 256;
   localparam int QUEUE_DEPTH = 2;

   localparam int STK_AW  = $clog2(STACK_DEPTH);
   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int SPX_W   = SP_W + 1;
   localparam int CNT_W   = $clog2(MAX_RUN + 1);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_BLOCK = 2'd0;
   localparam logic [1:0] KIND_PAIR  = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic       comp_mode;
      logic [7:0] run_mark;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_BLOCK,
      OP_PAIR,
      OP_RUN,
      OP_DATA
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
   } cmd_type;

   typedef struct packed {
      logic [7:0] left;
      logic [7:0] right;
   } pair_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_EVAL,
      ST_LOOK,
      ST_FIN
   } state_type;

endpackage

// ----- sv/bpd_ram.sv -----
module bpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bpd_front.sv -----
module bpd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpd_pkg::req_type  req_data,
   input  logic              queue_full,
   output logic              push,
   output bpd_pkg::cmd_type  push_cmd
);

   logic       compressed_ff, compressed_in;
   logic [7:0] marker_ff, marker_in;
   logic       accept;
   logic       keep;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      keep            = 1'b0;
      push_cmd.op     = bpd_pkg::OP_PAIR;
      push_cmd.byte_a = req_data.byte_a;
      push_cmd.byte_b = req_data.byte_b;
      compressed_in   = compressed_ff;
      marker_in       = marker_ff;
      case (req_data.kind)
         bpd_pkg::KIND_BLOCK: begin
            keep        = 1'b1;
            push_cmd.op = bpd_pkg::OP_BLOCK;
            if (accept) begin
               compressed_in = req_data.comp_mode;
               marker_in     = req_data.run_mark;
            end
         end
         bpd_pkg::KIND_PAIR: begin
            keep = 1'b1;
            if (compressed_ff && req_data.byte_a == marker_ff) begin
               push_cmd.op = bpd_pkg::OP_RUN;
               keep        = req_data.byte_b != 8'd0;
            end
         end
         bpd_pkg::KIND_DATA: begin
            keep        = 1'b1;
            push_cmd.op = bpd_pkg::OP_DATA;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = accept && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         compressed_ff <= 1'b0;
         marker_ff     <= 8'd0;
      end else begin
         compressed_ff <= compressed_in;
         marker_ff     <= marker_in;
      end
   end

endmodule

// ----- sv/bpd_queue.sv -----
module bpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bpd_pkg::cmd_type  push_cmd,
   output logic              full,
   output logic              head_valid,
   output bpd_pkg::cmd_type  head_cmd,
   input  logic              pop
);

   bpd_pkg::cmd_type            slot_ff [bpd_pkg::QUEUE_DEPTH];
   logic [bpd_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bpd_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bpd_pkg::QCNT_W-1:0]  count_ff, count_in;

   assign full       = count_ff == bpd_pkg::QCNT_W'(bpd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bpd_pkg::QPTR_W'(bpd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bpd_pkg::QPTR_W'(bpd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + bpd_pkg::QCNT_W'(push) - bpd_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/bpd_back.sv -----
module bpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  bpd_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpd_pkg::rsp_type  rsp_data
);

   bpd_pkg::state_type              state_ff, state_in;
   logic [bpd_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]                      fill_ff, fill_in;
   logic [7:0]                      run_ff, run_in;
   logic [bpd_pkg::SP_W-1:0]        sp_ff, sp_in;
   logic [bpd_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [7:0]                      x_ff, x_in;
   logic [7:0]                      pend_ff, pend_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic                            ovf_ff, ovf_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bpd_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                            pair_wr_en, pair_rd_en;
   logic [7:0]                      pair_wr_addr, pair_rd_addr;
   bpd_pkg::pair_type               pair_wr_data, pair_rd_data;
   logic                            stk_wr_en, stk_rd_en;
   logic [bpd_pkg::STK_AW-1:0]      stk_wr_addr, stk_rd_addr;
   logic [7:0]                      stk_wr_data, stk_rd_data;

   logic                            out_free;
   logic                            hit;
   logic [7:0]                      left, right;
   logic                            is_lit;
   logic [bpd_pkg::CNT_W-1:0]       cnt_inc;
   logic                            run_stop;
   logic                            stack_full;
   logic [bpd_pkg::SP_W-1:0]        sp_dec;

   bpd_ram #(
      .WIDTH ($bits(bpd_pkg::pair_type)),
      .DEPTH (bpd_pkg::TABLE_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_en   (pair_rd_en),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   bpd_ram #(
      .WIDTH (8),
      .DEPTH (bpd_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hit        = valid_ff[x_ff];
   assign left       = hit ? pair_rd_data.left : 8'd0;
   assign right      = hit ? pair_rd_data.right : 8'd0;
   assign is_lit     = left == x_ff;
   assign cnt_inc    = cnt_ff + 1'b1;
   assign run_stop   = (cnt_inc >= bpd_pkg::CNT_W'(bpd_pkg::MAX_RUN)) && (sp_ff != '0);
   assign stack_full = (bpd_pkg::SPX_W'(sp_ff) + bpd_pkg::SPX_W'(2)) >
                       bpd_pkg::SPX_W'(bpd_pkg::STACK_DEPTH);
   assign sp_dec     = sp_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpd_pkg::ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  bpd_pkg::OP_RUN:  state_in = bpd_pkg::ST_RUN;
                  bpd_pkg::OP_DATA: state_in = bpd_pkg::ST_EVAL;
                  default:          state_in = bpd_pkg::ST_IDLE;
               endcase
            end
         end
         bpd_pkg::ST_RUN: begin
            if (run_ff == 8'd1) begin
               state_in = bpd_pkg::ST_IDLE;
            end
         end
         bpd_pkg::ST_EVAL: begin
            if (is_lit) begin
               if (!pend_valid_ff || out_free) begin
                  state_in = (run_stop || sp_ff == '0) ? bpd_pkg::ST_FIN : bpd_pkg::ST_LOOK;
               end
            end else if (stack_full) begin
               state_in = bpd_pkg::ST_FIN;
            end
         end
         bpd_pkg::ST_LOOK: begin
            state_in = bpd_pkg::ST_EVAL;
         end
         bpd_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = bpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpd_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      q_pop         = 1'b0;
      valid_in      = valid_ff;
      fill_in       = fill_ff;
      run_in        = run_ff;
      sp_in         = sp_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      pair_wr_en    = 1'b0;
      pair_wr_addr  = fill_ff;
      pair_wr_data  = '{left: q_cmd.byte_a, right: q_cmd.byte_b};
      pair_rd_en    = 1'b0;
      pair_rd_addr  = q_cmd.byte_a;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = sp_ff[bpd_pkg::STK_AW-1:0];
      stk_wr_data   = right;
      stk_rd_en     = 1'b0;
      stk_rd_addr   = sp_dec[bpd_pkg::STK_AW-1:0];
      case (state_ff)
         bpd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.op)
                  bpd_pkg::OP_BLOCK: begin
                     valid_in = '0;
                     fill_in  = 8'd0;
                  end
                  bpd_pkg::OP_PAIR: begin
                     pair_wr_en        = 1'b1;
                     valid_in[fill_ff] = 1'b1;
                     fill_in           = fill_ff + 8'd1;
                  end
                  bpd_pkg::OP_RUN: begin
                     run_in = q_cmd.byte_b;
                  end
                  bpd_pkg::OP_DATA: begin
                     x_in          = q_cmd.byte_a;
                     pair_rd_en    = 1'b1;
                     sp_in         = '0;
                     cnt_in        = '0;
                     pend_valid_in = 1'b0;
                     ovf_in        = 1'b0;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         bpd_pkg::ST_RUN: begin
            pair_wr_en        = 1'b1;
            pair_wr_data      = '{left: fill_ff, right: 8'd0};
            valid_in[fill_ff] = 1'b1;
            fill_in           = fill_ff + 8'd1;
            run_in            = run_ff - 8'd1;
         end
         bpd_pkg::ST_EVAL: begin
            if (is_lit) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{out_byte: pend_ff, last: 1'b0, overflow: 1'b0};
                  end
                  pend_in       = x_ff;
                  pend_valid_in = 1'b1;
                  cnt_in        = cnt_inc;
                  if (run_stop) begin
                     ovf_in = 1'b1;
                  end else if (sp_ff != '0) begin
                     stk_rd_en = 1'b1;
                     sp_in     = sp_dec;
                  end
               end
            end else if (stack_full) begin
               ovf_in = 1'b1;
            end else begin
               // push right, walk left directly
               stk_wr_en    = 1'b1;
               sp_in        = sp_ff + 1'b1;
               x_in         = left;
               pair_rd_en   = 1'b1;
               pair_rd_addr = left;
            end
         end
         bpd_pkg::ST_LOOK: begin
            x_in         = stk_rd_data;
            pair_rd_en   = 1'b1;
            pair_rd_addr = stk_rd_data;
         end
         bpd_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in = '{out_byte: pend_ff, last: 1'b1, overflow: ovf_ff};
               end else begin
                  rsp_data_in = '{out_byte: 8'd0, last: 1'b1, overflow: 1'b1};
               end
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpd_pkg::ST_IDLE;
         valid_ff      <= '0;
         fill_ff       <= 8'd0;
         sp_ff         <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         fill_ff       <= fill_in;
         sp_ff         <= sp_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff      <= run_in;
      x_ff        <= x_in;
      pend_ff     <= pend_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/byte_pair_decoder_top.sv -----
// Byte-pair decompressor. Items enter a two-entry command queue, one per cycle;
// req_stall rises only when that queue is full. The back end runs one command at a
// time: block start and table pair are taken in the idle state, a marker run writes
// one table entry per cycle, and a data byte is expanded by walking its pair nodes,
// pushing each right child on the stack, and emitting each literal; each literal
// but the last needs a stack RAM pop and a pair RAM lookup, both with registered reads.
// The pair table needs no clearing pass after reset or block start; per-entry valid
// flops cover it. One result is held back until the end of its expansion is known.
module byte_pair_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpd_pkg::rsp_type  rsp_data
);

   logic             push;
   bpd_pkg::cmd_type push_cmd;
   logic             queue_full;
   logic             head_valid;
   bpd_pkg::cmd_type head_cmd;
   logic             pop;

   bpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   bpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   bpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_cmd     (head_cmd),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/bpd_checker.sv -----
module bpd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bpd_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bpd_pkg::rsp_type  rsp_data
);

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // overflow only ends an expansion
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.last)
      else $error("overflow without last");

   // reset empties queue and result register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // a result appears only after some input transfer since reset
   a_no_early_rsp: assert property (@(posedge clock)
      reset ##1 !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result without input");

endmodule

bind byte_pair_decoder_top bpd_checker u_bpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
